// File: rtl/dsrp_pkg.sv
package dsrp_pkg;

  localparam int STEPS_W   = 32;
  localparam int PULSE_W   = 31;
  localparam int ELAPSED_W = 32;
  localparam int USEC_W    = 20;
  localparam int RAMP_W    = 31;
  localparam int RATE_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL = 3'd5;

  typedef enum logic [1:0] {
    ACT_MOVE  = 2'd0,
    ACT_BRAKE = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_TICK  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    MS_STOP   = 2'd0,
    MS_ACCEL  = 2'd1,
    MS_CRUISE = 2'd2,
    MS_DECEL  = 2'd3
  } ms_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LATCH = 3'd1,
    OP_EXEC  = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIVGO = 3'd4,
    OP_FIT   = 3'd5,
    OP_RESP  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    JOB_START1 = 2'd0,
    JOB_START2 = 2'd1,
    JOB_BRAKE  = 2'd2,
    JOB_PULSE  = 2'd3
  } job_e;

  typedef struct packed {
    op_e  op;
    job_e job;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic moving;
    ms_e  st;
    logic mode;
    logic fire;
    logic short_fit;
    logic div_done;
  } stat_t;

endpackage

// File: rtl/dual_stepper_ramp_pulse_generator.sv
// stop, brake, plain moves and ticks: latch, execute, then respond once the output is free
// a tick that steps on a ramp and an early brake while accelerating run the shared
// one-bit-per-cycle divider once
// an accelerated move start runs it up to twice
// throughput: one item at a time, next item taken while the result waits
// reset: async active low, config to its defaults, motion stopped, direction forward
module dual_stepper_ramp_pulse_generator import dsrp_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  // command items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic signed [STEPS_W-1:0] steps_i,
  input  logic                 rotate_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 step_now_o,
  output logic                 left_dir_o,
  output logic                 right_dir_o,
  output logic                 moving_o,
  output logic [1:0]           motion_state_o,
  output logic [PULSE_W-1:0]   interval_us_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: latch, execute, optional multiply and divide, respond
  dsrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // profile state, step counters, recurrence arithmetic and output register
  dsrp_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .steps_i        (steps_i),
    .rotate_i       (rotate_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .step_now_o     (step_now_o),
    .left_dir_o     (left_dir_o),
    .right_dir_o    (right_dir_o),
    .moving_o       (moving_o),
    .motion_state_o (motion_state_o),
    .interval_us_o  (interval_us_o)
  );

  // an accepted item always needs at least the execute cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // a stopped result reports no remaining steps
  a_stop_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_state_o == MS_STOP |-> !moving_o)
    else $error("stopped but moving");

  // any other motion state means steps remain
  a_motion_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_state_o != MS_STOP |-> moving_o)
    else $error("motion without steps");

  // a result can only be replaced once it has been taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(interval_us_o))
    else $error("result dropped");

endmodule

// File: rtl/dsrp_div.sv
module dsrp_div #(
  parameter int DW = 50
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    dvs_q;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             ge;

  // restoring, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = !diff[DW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/dsrp_dp.sv
module dsrp_dp import dsrp_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  input  logic [1:0]           action_i,
  input  logic [STEPS_W-1:0]   steps_i,
  input  logic                 rotate_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  output logic                 step_now_o,
  output logic                 left_dir_o,
  output logic                 right_dir_o,
  output logic                 moving_o,
  output logic [1:0]           motion_state_o,
  output logic [PULSE_W-1:0]   interval_us_o
);

  localparam int CW = COUNT_WIDTH;
  localparam int DW = CW + 18;
  localparam int MW = ((CW > STEPS_W) ? CW : STEPS_W) + 1;
  localparam int RW = CW + 4;
  localparam int NW = ((CW > PULSE_W) ? CW : PULSE_W) + 6;
  localparam int PW = CW + RATE_W;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  // configuration
  logic              mode_q;
  logic [USEC_W-1:0] const_q, init_q;
  logic [RAMP_W-1:0] ramp_q;
  logic [RATE_W-1:0] accel_q, decel_q;

  // latched item
  act_e               act_q;
  logic [STEPS_W-1:0] steps_q;
  logic               rot_q;

  // motion state
  logic [CW-1:0]        rem_q, rem_d, done_q, done_d;
  logic [CW-1:0]        cruise_q, cruise_d, brake_q, brake_d;
  logic [PULSE_W-1:0]   pulse_q, pulse_d;
  logic signed [RW-1:0] rmd_q, rmd_d;
  logic [ELAPSED_W-1:0] wait_q, wait_d, elapsed_q, elapsed_d;
  logic                 dir_q, dir_d, rotating_q, rotating_d;
  logic                 stepped_q, stepped_d;
  logic                 qneg_q, rneg_q, decp_q;
  logic [DW-1:0]        prod_q;

  logic                 out_step_q, out_ldir_q, out_rdir_q, out_moving_q;
  logic [1:0]           out_ms_q;
  logic [PULSE_W-1:0]   out_pulse_q;

  ms_e                  st;
  logic [RATE_W-1:0]    a_eff, d_eff;
  logic [RATE_W:0]      apd;
  logic                 neg;
  logic [STEPS_W-1:0]   mag;
  logic [MW-1:0]        mag_w, ramp_w, sum_w, rem_w;
  logic [CW-1:0]        mag_sat, ramp_sat, sum_sat, left;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 fire;
  logic [CW-1:0]        done_inc;
  logic [CW-1:0]        mul_a;
  logic [RATE_W-1:0]    mul_b;
  logic [PW-1:0]        prod_w;
  logic signed [NW-1:0] num;
  logic [NW-1:0]        num_mag;
  logic                 dec;
  logic [CW+2:0]        den_mag;
  logic                 div_start;
  logic [DW-1:0]        div_a, div_b, quo, rmd_raw;
  logic                 div_done;
  logic [CW-1:0]        q_sat;
  logic signed [DW+1:0] qs, diff;
  logic [PULSE_W-1:0]   pulse_fit;
  logic signed [RW-1:0] rs;
  logic                 short_fit;

  always_comb begin
    if (rem_q == '0)             st = MS_STOP;
    else if (rem_q <= brake_q)   st = MS_DECEL;
    else if (done_q <= cruise_q) st = MS_ACCEL;
    else                         st = MS_CRUISE;
  end

  always_comb begin
    a_eff    = (accel_q == '0) ? RATE_W'(1) : accel_q;
    d_eff    = (decel_q == '0) ? RATE_W'(1) : decel_q;
    apd      = (RATE_W+1)'(a_eff) + (RATE_W+1)'(d_eff);
    neg      = steps_q[STEPS_W-1];
    mag      = neg ? (~steps_q + 1'b1) : steps_q;
    mag_w    = MW'(mag);
    ramp_w   = MW'(ramp_q);
    sum_w    = MW'(rem_q) + MW'(steps_q[STEPS_W-2:0]);
    rem_w    = MW'(rem_q);
    mag_sat  = (mag_w > MW'(COUNT_MAX)) ? COUNT_MAX : mag_w[CW-1:0];
    ramp_sat = (ramp_w > MW'(COUNT_MAX)) ? COUNT_MAX : ramp_w[CW-1:0];
    sum_sat  = (sum_w > MW'(COUNT_MAX)) ? COUNT_MAX : sum_w[CW-1:0];
    left     = (mag_w >= rem_w) ? '0 : CW'(rem_w - mag_w);
    elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
    fire     = elapsed_inc > wait_q;
    done_inc = (done_q == COUNT_MAX) ? done_q : done_q + 1'b1;
    short_fit = ((CW+1)'(cruise_q) + (CW+1)'(brake_q)) > (CW+1)'(rem_q);
  end

  // product for the ramp fitting and early braking
  always_comb begin
    case (cmd_i.job)
      JOB_START1: begin mul_a = cruise_q; mul_b = a_eff; end
      JOB_START2: begin mul_a = rem_q;    mul_b = d_eff; end
      default:    begin mul_a = done_q;   mul_b = a_eff; end
    endcase
    prod_w = PW'(mul_a) * PW'(mul_b);
  end

  // divider operands for the recurrence and the ramp fits, signs handled outside the divider
  always_comb begin
    num     = $signed((NW'(pulse_q) << 1)) + NW'(rmd_q);
    num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    dec     = (st == MS_DECEL);
    den_mag = dec ? ((CW+3)'({rem_q, 2'b00}) - 1'b1) : ((CW+3)'({done_q, 2'b00}) + 1'b1);
    div_start = (cmd_i.op == OP_DIVGO);
    case (cmd_i.job)
      JOB_PULSE:  begin div_a = DW'(num_mag); div_b = DW'(den_mag); end
      JOB_START2: begin div_a = prod_q;       div_b = DW'(apd);     end
      default:    begin div_a = prod_q;       div_b = DW'(d_eff);   end
    endcase
  end

  dsrp_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rmd_raw)
  );

  always_comb begin
    q_sat = (|quo[DW-1:CW]) ? COUNT_MAX : quo[CW-1:0];
    qs    = qneg_q ? -((DW+2)'(quo)) : (DW+2)'(quo);
    diff  = $signed((DW+2)'(pulse_q)) - qs;
    if (diff[DW+1])            pulse_fit = '0;
    else if (|diff[DW:PULSE_W]) pulse_fit = '1;
    else                       pulse_fit = diff[PULSE_W-1:0];
    rs    = rneg_q ? -$signed(rmd_raw[RW-1:0]) : $signed(rmd_raw[RW-1:0]);
  end

  always_comb begin
    rem_d      = rem_q;
    done_d     = done_q;
    cruise_d   = cruise_q;
    brake_d    = brake_q;
    pulse_d    = pulse_q;
    rmd_d      = rmd_q;
    wait_d     = wait_q;
    elapsed_d  = elapsed_q;
    dir_d      = dir_q;
    rotating_d = rotating_q;
    stepped_d  = stepped_q;
    case (cmd_i.op)
      OP_LATCH: stepped_d = 1'b0;
      OP_EXEC: begin
        case (act_q)
          ACT_MOVE: begin
            if (rem_q == '0) begin
              dir_d      = !neg;
              rotating_d = rot_q;
              elapsed_d  = '0;
              wait_d     = '0;
              rem_d      = mag_sat;
              done_d     = '0;
              rmd_d      = '0;
              if (mode_q) begin
                cruise_d = ramp_sat;
                pulse_d  = PULSE_W'(init_q);
              end else begin
                cruise_d = '0;
                brake_d  = '0;
                pulse_d  = PULSE_W'(const_q);
              end
            end else if (st == MS_ACCEL || st == MS_CRUISE) begin
              rotating_d = rot_q;
              if (!neg) rem_d = sum_sat;
              else      rem_d = (left > brake_q) ? left : brake_q;
            end
          end
          ACT_BRAKE: begin
            if (st == MS_CRUISE) rem_d = brake_q;
          end
          ACT_STOP: rem_d = '0;
          ACT_TICK: begin
            if (rem_q == '0) begin
              wait_d    = '0;
              elapsed_d = '0;
            end else if (fire) begin
              stepped_d = 1'b1;
              rem_d     = rem_q - 1'b1;
              done_d    = done_inc;
              elapsed_d = '0;
              wait_d    = (pulse_q == '0) ? ELAPSED_W'(1) : ELAPSED_W'(pulse_q);
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
          default: ;
        endcase
      end
      OP_FIT: begin
        case (cmd_i.job)
          JOB_START1: brake_d = q_sat;
          JOB_START2: begin
            cruise_d = quo[CW-1:0];
            brake_d  = rem_q - quo[CW-1:0];
          end
          JOB_BRAKE: rem_d = q_sat;
          JOB_PULSE: begin
            pulse_d = pulse_fit;
            if (decp_q)                rmd_d = rs;
            else if (done_q < cruise_q) rmd_d = rs;
            else                       rmd_d = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      const_q    <= USEC_W'(1000);
      init_q     <= USEC_W'(10000);
      ramp_q     <= '0;
      accel_q    <= RATE_W'(1000);
      decel_q    <= RATE_W'(1000);
      rem_q      <= '0;
      done_q     <= '0;
      cruise_q   <= '0;
      brake_q    <= '0;
      pulse_q    <= '0;
      rmd_q      <= '0;
      wait_q     <= '0;
      elapsed_q  <= '0;
      dir_q      <= 1'b1;
      rotating_q <= 1'b0;
      stepped_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:  mode_q  <= cfg_wdata_i[0];
          CFG_CONST: const_q <= cfg_wdata_i[USEC_W-1:0];
          CFG_INIT:  init_q  <= cfg_wdata_i[USEC_W-1:0];
          CFG_RAMP:  ramp_q  <= cfg_wdata_i[RAMP_W-1:0];
          CFG_ACCEL: accel_q <= cfg_wdata_i[RATE_W-1:0];
          CFG_DECEL: decel_q <= cfg_wdata_i[RATE_W-1:0];
          default: ;
        endcase
      end
      rem_q      <= rem_d;
      done_q     <= done_d;
      cruise_q   <= cruise_d;
      brake_q    <= brake_d;
      pulse_q    <= pulse_d;
      rmd_q      <= rmd_d;
      wait_q     <= wait_d;
      elapsed_q  <= elapsed_d;
      dir_q      <= dir_d;
      rotating_q <= rotating_d;
      stepped_q  <= stepped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      act_q   <= act_e'(action_i);
      steps_q <= steps_i;
      rot_q   <= rotate_i;
    end
    if (cmd_i.op == OP_MUL) prod_q <= DW'(prod_w);
    if (cmd_i.op == OP_DIVGO) begin
      qneg_q <= num[NW-1] ^ dec;
      rneg_q <= num[NW-1];
      decp_q <= dec;
    end
    if (cmd_i.op == OP_RESP) begin
      out_step_q   <= stepped_q;
      out_ldir_q   <= dir_q;
      out_rdir_q   <= dir_q ^ rotating_q;
      out_moving_q <= (rem_q != '0);
      out_ms_q     <= st;
      out_pulse_q  <= pulse_q;
    end
  end

  always_comb begin
    stat_o.act       = act_q;
    stat_o.moving    = (rem_q != '0);
    stat_o.st        = st;
    stat_o.mode      = mode_q;
    stat_o.fire      = fire;
    stat_o.short_fit = short_fit;
    stat_o.div_done  = div_done;
  end

  assign step_now_o     = out_step_q;
  assign left_dir_o     = out_ldir_q;
  assign right_dir_o    = out_rdir_q;
  assign moving_o       = out_moving_q;
  assign motion_state_o = out_ms_q;
  assign interval_us_o  = out_pulse_q;

endmodule

// File: rtl/dsrp_ctrl.sv
module dsrp_ctrl import dsrp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_PCHK  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_DIVGO = 9'b000010000,
    S_WAIT  = 9'b000100000,
    S_FIT   = 9'b001000000,
    S_CHK   = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   out_valid_q, out_valid_d;
  logic   resp_go;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    cmd_o.op  = OP_NONE;
    cmd_o.job = job_q;
    resp_go   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = OP_EXEC;
        state_d  = S_RESP;
        case (stat_i.act)
          ACT_MOVE: begin
            if (!stat_i.moving && stat_i.mode) begin
              job_d   = JOB_START1;
              state_d = S_MUL;
            end
          end
          ACT_BRAKE: begin
            if (stat_i.st == MS_ACCEL) begin
              job_d   = JOB_BRAKE;
              state_d = S_MUL;
            end
          end
          ACT_TICK: begin
            if (stat_i.moving && stat_i.fire && stat_i.mode) begin
              job_d   = JOB_PULSE;
              state_d = S_PCHK;
            end
          end
          default: ;
        endcase
      end
      S_PCHK: begin
        if (stat_i.st == MS_ACCEL || stat_i.st == MS_DECEL) state_d = S_DIVGO;
        else                                                  state_d = S_RESP;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_DIVGO;
      end
      S_DIVGO: begin
        cmd_o.op = OP_DIVGO;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.div_done) state_d = S_FIT;
      end
      S_FIT: begin
        cmd_o.op = OP_FIT;
        state_d  = (job_q == JOB_START1) ? S_CHK : S_RESP;
      end
      S_CHK: begin
        if (stat_i.short_fit) begin
          job_d   = JOB_START2;
          state_d = S_MUL;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_RESP;
          resp_go  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (resp_go)          out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= JOB_START1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dsrp_pkg::*;

  localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF;
  localparam longint PULSE_MAX = 64'h7FFF_FFFF;
  localparam longint unsigned ELAPSED_MAX = 64'hFFFF_FFFF;
  // longest divider job plus response slack
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    logic         step_now;
    logic         left_dir;
    logic         right_dir;
    logic         moving;
    ms_e          state;
    logic [30:0]  interval;
  } motion_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_MODE;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] action_i = ACT_TICK;
  logic signed [STEPS_W-1:0] steps_i = '0;
  logic rotate_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic step_now_o, left_dir_o, right_dir_o, moving_o;
  logic [1:0] motion_state_o;
  logic [PULSE_W-1:0] interval_us_o;

  dual_stepper_ramp_pulse_generator u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .action_i, .steps_i, .rotate_i,
    .out_valid_o, .out_ready_i, .step_now_o, .left_dir_o, .right_dir_o,
    .moving_o, .motion_state_o, .interval_us_o
  );

  always #5 clk_i = ~clk_i;

  // shadow of the configuration registers
  longint unsigned mode_q, const_us_q, init_us_q, ramp_q, accel_q, decel_q;
  // shadow of the motion state
  longint unsigned steps_left, steps_done, cruise_until, brake_from;
  longint unsigned wait_us, elapsed_us;
  longint pulse_us, pulse_rem;
  logic fwd, spin;

  motion_out_t motion_q[$];
  int errors = 0;
  int items_sent = 0;
  int tx_idle_pct = 17;
  int rx_idle_pct = 17;
  int hold_req = 0;
  logic offering = 1'b0;

  function automatic longint unsigned sat_count(longint unsigned v);
    return (v > COUNT_MAX) ? COUNT_MAX : v;
  endfunction

  function automatic longint clamp_pulse(longint v);
    if (v < 0) return 0;
    return (v > PULSE_MAX) ? PULSE_MAX : v;
  endfunction

  function automatic ms_e phase_now();
    if (steps_left == 0) return MS_STOP;
    if (steps_left <= brake_from) return MS_DECEL;
    if (steps_done <= cruise_until) return MS_ACCEL;
    return MS_CRUISE;
  endfunction

  function automatic longint unsigned rate(longint unsigned r);
    return (r == 0) ? 1 : r;
  endfunction

  // plan a fresh move from standstill
  function automatic void plan_move(logic [31:0] raw, logic rot);
    longint unsigned mag, a, d;
    mag = raw[31] ? {32'd0, 32'(~raw + 32'd1)} : {32'd0, raw};
    a = rate(accel_q);
    d = rate(decel_q);
    fwd = ~raw[31];
    spin = rot;
    elapsed_us = 0;
    wait_us = 0;
    steps_left = sat_count(mag);
    steps_done = 0;
    pulse_rem = 0;
    if (mode_q != 0) begin
      cruise_until = sat_count(ramp_q);
      brake_from = sat_count(cruise_until * a / d);
      // short move: split it between ramp up and ramp down
      if (steps_left < cruise_until + brake_from) begin
        cruise_until = steps_left * d / (a + d);
        brake_from = steps_left - cruise_until;
      end
      pulse_us = longint'(init_us_q);
    end else begin
      pulse_us = longint'(const_us_q);
      cruise_until = 0;
      brake_from = 0;
    end
  endfunction

  // extend or trim a running move, ignored while braking
  function automatic void adjust_move(logic [31:0] raw, logic rot);
    longint unsigned mag, left;
    ms_e st;
    st = phase_now();
    if (st != MS_ACCEL && st != MS_CRUISE) return;
    spin = rot;
    if (!raw[31]) begin
      steps_left = sat_count(steps_left + {32'd0, raw});
    end else begin
      mag = {32'd0, 32'(~raw + 32'd1)};
      left = (mag >= steps_left) ? 0 : steps_left - mag;
      steps_left = (left > brake_from) ? left : brake_from;
    end
  endfunction

  // one step taken: advance counters and the interval recurrence
  function automatic void advance_step();
    longint num, den;
    ms_e st;
    if (steps_left == 0) return;
    steps_left--;
    steps_done = sat_count(steps_done + 1);
    if (mode_q == 0) return;
    st = phase_now();
    num = 2 * pulse_us + pulse_rem;
    if (st == MS_ACCEL) begin
      den = 4 * longint'(steps_done) + 1;
      pulse_us = clamp_pulse(pulse_us - num / den);
      pulse_rem = (steps_done < cruise_until) ? num % den : 0;
    end else if (st == MS_DECEL) begin
      den = 1 - 4 * longint'(steps_left);
      pulse_us = clamp_pulse(pulse_us - num / den);
      pulse_rem = num % den;
    end
  endfunction

  function automatic motion_out_t predict_motion(act_e act, logic [31:0] raw, logic rot);
    motion_out_t r;
    longint used;
    r.step_now = 1'b0;
    case (act)
      ACT_MOVE: begin
        if (steps_left > 0) adjust_move(raw, rot);
        else plan_move(raw, rot);
      end
      ACT_BRAKE: begin
        if (phase_now() == MS_CRUISE) steps_left = brake_from;
        else if (phase_now() == MS_ACCEL)
          steps_left = sat_count(steps_done * rate(accel_q) / rate(decel_q));
      end
      ACT_STOP: steps_left = 0;
      default: begin
        if (steps_left == 0) begin
          wait_us = 0;
          elapsed_us = 0;
        end else begin
          if (elapsed_us < ELAPSED_MAX) elapsed_us++;
          if (elapsed_us > wait_us) begin
            used = pulse_us;
            r.step_now = 1'b1;
            advance_step();
            elapsed_us = 0;
            wait_us = (used > 0) ? longint'(used) : 1;
          end
        end
      end
    endcase
    r.left_dir = fwd;
    r.right_dir = fwd ^ spin;
    r.moving = (steps_left > 0);
    r.state = phase_now();
    r.interval = 31'(clamp_pulse(pulse_us));
    return r;
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_cmd(act_e act, logic [31:0] raw, logic rot);
    in_valid_i <= 1'b1;
    offering = 1'b1;
    action_i <= act;
    steps_i <= raw;
    rotate_i <= rot;
    do @(posedge clk_i); while (!in_ready_o);
    motion_q.push_back(predict_motion(act, raw, rot));
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic tick_run(int n);
    for (int i = 0; i < n && steps_left != 0; i++) send_cmd(ACT_TICK, '0, 1'b0);
  endtask

  // stop offering, wait for every result, then let the block settle
  task automatic drain();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (motion_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE:  mode_q = val[0];
      CFG_CONST: const_us_q = val[USEC_W-1:0];
      CFG_INIT:  init_us_q = val[USEC_W-1:0];
      CFG_RAMP:  ramp_q = val[RAMP_W-1:0];
      CFG_ACCEL: accel_q = val[RATE_W-1:0];
      CFG_DECEL: decel_q = val[RATE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    int hold_left;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    motion_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (motion_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got step %b state %0d", $time,
                 step_now_o, motion_state_o);
        errors++;
      end else begin
        e = motion_q.pop_front();
        if (step_now_o !== e.step_now) begin
          $display("%0t: step_now expected %b actual %b", $time, e.step_now, step_now_o);
          errors++;
        end
        if (left_dir_o !== e.left_dir) begin
          $display("%0t: left_dir expected %b actual %b", $time, e.left_dir, left_dir_o);
          errors++;
        end
        if (right_dir_o !== e.right_dir) begin
          $display("%0t: right_dir expected %b actual %b", $time, e.right_dir, right_dir_o);
          errors++;
        end
        if (moving_o !== e.moving) begin
          $display("%0t: moving expected %b actual %b", $time, e.moving, moving_o);
          errors++;
        end
        if (motion_state_o !== e.state) begin
          $display("%0t: motion_state expected %0d actual %0d", $time, e.state,
                   motion_state_o);
          errors++;
        end
        if (interval_us_o !== e.interval) begin
          $display("%0t: interval_us expected %0d actual %0d", $time, e.interval,
                   interval_us_o);
          errors++;
        end
      end
    end
  end

  // an idle tick, stop and brake at rest and default directions right after reset
  task automatic test_reset_state();
    send_cmd(ACT_TICK, '0, 1'b0);
    send_cmd(ACT_STOP, '0, 1'b0);
    send_cmd(ACT_BRAKE, '0, 1'b0);
    drain();
  endtask

  // constant speed, both directions, rotate in place, empty move
  task automatic test_constant_speed();
    set_reg(CFG_MODE, 31'd0);
    set_reg(CFG_CONST, 31'd1);
    send_cmd(ACT_MOVE, 32'd3, 1'b1);
    tick_run(8);
    send_cmd(ACT_MOVE, -32'sd2, 1'b0);
    send_cmd(ACT_BRAKE, '0, 1'b0);
    send_cmd(ACT_MOVE, 32'd0, 1'b1);
    send_cmd(ACT_TICK, '0, 1'b0);
    drain();
  endtask

  // trapezoid with alter, trim below brake count and early brake
  task automatic test_ramp_profile();
    set_reg(CFG_MODE, 31'd1);
    set_reg(CFG_INIT, 31'd12);
    set_reg(CFG_RAMP, 31'd6);
    set_reg(CFG_ACCEL, 31'd2);
    set_reg(CFG_DECEL, 31'd3);
    send_cmd(ACT_MOVE, 32'd40, 1'b0);
    tick_run(30);
    send_cmd(ACT_MOVE, 32'd5, 1'b1);
    send_cmd(ACT_MOVE, -32'sd100, 1'b0);
    tick_run(200);
    send_cmd(ACT_MOVE, -32'sd30, 1'b0);
    tick_run(20);
    send_cmd(ACT_BRAKE, '0, 1'b0);
    send_cmd(ACT_MOVE, 32'd9, 1'b0);
    tick_run(200);
    drain();
    // mode switched with a move still pending
    send_cmd(ACT_MOVE, 32'd20, 1'b0);
    tick_run(3);
    drain();
    set_reg(CFG_MODE, 31'd0);
    set_reg(CFG_CONST, 31'd2);
    tick_run(80);
    drain();
  endtask

  // register and step count extremes
  task automatic test_extremes();
    set_reg(CFG_MODE, 31'd0);
    set_reg(CFG_CONST, 31'd1000000);
    send_cmd(ACT_MOVE, 32'h7FFF_FFFF, 1'b1);
    send_cmd(ACT_TICK, '0, 1'b0);
    send_cmd(ACT_MOVE, 32'h7FFF_FFFF, 1'b0);
    send_cmd(ACT_TICK, '0, 1'b0);
    send_cmd(ACT_STOP, '0, 1'b0);
    drain();
    set_reg(CFG_MODE, 31'd1);
    set_reg(CFG_INIT, 31'd1000000);
    set_reg(CFG_RAMP, 31'h7FFF_FFFF);
    set_reg(CFG_ACCEL, 31'd32767);
    set_reg(CFG_DECEL, 31'd1);
    send_cmd(ACT_MOVE, 32'h8000_0000, 1'b1);
    send_cmd(ACT_BRAKE, '0, 1'b0);
    send_cmd(ACT_MOVE, 32'h8000_0000, 1'b0);
    send_cmd(ACT_TICK, '0, 1'b0);
    send_cmd(ACT_BRAKE, '0, 1'b0);
    send_cmd(ACT_STOP, '0, 1'b0);
    drain();
    set_reg(CFG_ACCEL, 31'd1);
    set_reg(CFG_DECEL, 31'd32767);
    set_reg(CFG_INIT, 31'd1);
    set_reg(CFG_CONST, 31'd1);
    set_reg(CFG_RAMP, 31'd0);
    send_cmd(ACT_MOVE, 32'd5, 1'b0);
    tick_run(20);
    drain();
  endtask

  task automatic random_config();
    set_reg(CFG_MODE, 31'($urandom_range(1)));
    set_reg(CFG_CONST, 31'($urandom_range(1, 6)));
    set_reg(CFG_INIT, 31'($urandom_range(1, 30)));
    if ($urandom_range(7) == 0) set_reg(CFG_RAMP, 31'($urandom));
    else set_reg(CFG_RAMP, 31'($urandom_range(0, 30)));
    if ($urandom_range(7) == 0) set_reg(CFG_ACCEL, 31'($urandom_range(1, 32767)));
    else set_reg(CFG_ACCEL, 31'($urandom_range(1, 8)));
    if ($urandom_range(7) == 0) set_reg(CFG_DECEL, 31'($urandom_range(1, 32767)));
    else set_reg(CFG_DECEL, 31'($urandom_range(1, 8)));
  endtask

  function automatic logic [31:0] random_steps();
    int pick;
    logic [31:0] mag;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom;
    if (pick < 14) return '0;
    mag = $urandom_range(1, 60);
    return $urandom_range(1) ? mag : -mag;
  endfunction

  // well-formed moves with random content, mixed with noise
  task automatic test_random_moves(int budget);
    int stop_at, pick;
    for (int ph = 0; items_sent < budget; ph++) begin
      random_config();
      tx_idle_pct = (ph % 4 == 1) ? 0 : 17;
      rx_idle_pct = (ph % 4 == 1) ? 0 : 17;
      stop_at = items_sent + 130;
      while (items_sent < stop_at && items_sent < budget) begin
        pick = $urandom_range(99);
        if (steps_left == 0) begin
          if (pick < 85) send_cmd(ACT_MOVE, random_steps(), 1'($urandom));
          else send_cmd(act_e'($urandom_range(1, 3)), $urandom, 1'($urandom));
        end else if (steps_left > 100000 && pick < 10) begin
          send_cmd(ACT_STOP, $urandom, 1'($urandom));
        end else if (pick < 90) begin
          send_cmd(ACT_TICK, $urandom, 1'($urandom));
        end else if (pick < 94) begin
          send_cmd(ACT_BRAKE, $urandom, 1'($urandom));
        end else if (pick < 98) begin
          send_cmd(ACT_MOVE, random_steps(), 1'($urandom));
        end else begin
          send_cmd(ACT_STOP, $urandom, 1'($urandom));
        end
      end
      drain();
    end
    tx_idle_pct = 17;
    rx_idle_pct = 17;
  endtask

  // long receiver hold-off while commands keep coming
  task automatic test_output_stall();
    set_reg(CFG_MODE, 31'd1);
    set_reg(CFG_INIT, 31'd3);
    set_reg(CFG_RAMP, 31'd4);
    tx_idle_pct = 0;
    hold_req = 400;
    send_cmd(ACT_MOVE, 32'd30, 1'b1);
    for (int i = 0; i < 30; i++) send_cmd(ACT_TICK, '0, 1'b0);
    tx_idle_pct = 17;
    drain();
  endtask

  initial begin
    mode_q = 0; const_us_q = 1000; init_us_q = 10000;
    ramp_q = 0; accel_q = 1000; decel_q = 1000;
    steps_left = 0; steps_done = 0; cruise_until = 0; brake_from = 0;
    wait_us = 0; elapsed_us = 0; pulse_us = 0; pulse_rem = 0;
    fwd = 1'b1; spin = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_constant_speed();
    test_ramp_profile();
    test_extremes();
    test_output_stall();
    test_random_moves(1100);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
